/* rtl/mrf_pkg.sv */
// types, codes and frame layout for the modbus rtu request framer
package mrf_pkg;

	localparam int IdxW = 4;

	localparam logic [1:0] FUNC_READ  = 2'd0;
	localparam logic [1:0] FUNC_WRITE = 2'd1;
	localparam logic [1:0] FUNC_RW    = 2'd2;
	localparam logic [1:0] FUNC_NONE  = 2'd3;

	localparam logic [7:0] FC_READ       = 8'h03;
	localparam logic [7:0] FC_WRITE      = 8'h10;
	localparam logic [7:0] FC_READ_WRITE = 8'h17;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [7:0] SLAVE_RESET = 8'h01;

	typedef struct packed {
		logic [1:0]  func;
		logic [15:0] reg_address;
		logic [15:0] reg_value;
		logic [7:0]  read_count;
	} req_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last_byte;
	} frm_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BODY,
		ST_CRC_LO,
		ST_CRC_HI
	} mrf_state_t;

	// number of bytes before the crc
	function automatic logic [IdxW-1:0] mrf_body_len(input logic [1:0] func);
		logic [IdxW-1:0] len;
		case (func)
			FUNC_READ:  len = IdxW'(6);
			FUNC_WRITE: len = IdxW'(9);
			default:    len = IdxW'(13);
		endcase
		return len;
	endfunction

	function automatic logic [7:0] mrf_body_byte(
		input logic [7:0]      slave,
		input req_t            req,
		input logic [IdxW-1:0] idx
	);
		logic [7:0] ah;
		logic [7:0] al;
		logic [7:0] vh;
		logic [7:0] vl;
		logic [7:0] b;
		ah = req.reg_address[15:8];
		al = req.reg_address[7:0];
		vh = req.reg_value[15:8];
		vl = req.reg_value[7:0];
		b  = 8'h00;
		case (req.func)
			FUNC_READ: begin
				case (idx)
					4'd0:    b = slave;
					4'd1:    b = FC_READ;
					4'd2:    b = ah;
					4'd3:    b = al;
					4'd5:    b = req.read_count;
					default: b = 8'h00;
				endcase
			end
			FUNC_WRITE: begin
				case (idx)
					4'd0:    b = slave;
					4'd1:    b = FC_WRITE;
					4'd2:    b = ah;
					4'd3:    b = al;
					4'd5:    b = 8'h01;
					4'd6:    b = 8'h02;
					4'd7:    b = vh;
					4'd8:    b = vl;
					default: b = 8'h00;
				endcase
			end
			default: begin
				case (idx)
					4'd0:    b = slave;
					4'd1:    b = FC_READ_WRITE;
					4'd2:    b = ah;
					4'd3:    b = al;
					4'd5:    b = 8'h01;
					4'd6:    b = ah;
					4'd7:    b = al;
					4'd9:    b = 8'h01;
					4'd10:   b = 8'h02;
					4'd11:   b = vh;
					4'd12:   b = vl;
					default: b = 8'h00;
				endcase
			end
		endcase
		return b;
	endfunction

endpackage

/* rtl/mrf_crc_step.sv */
// crc-16/modbus update over one byte, the shared unit of the framer
module mrf_crc_step
	import mrf_pkg::*;
(
	input  logic [15:0] crc,
	input  logic [7:0]  data,
	output logic [15:0] crc_next
);

	always_comb begin
		logic [15:0] c;
		c = crc ^ {8'h00, data};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		crc_next = c;
	end

endmodule

/* rtl/modbus_rtu_request_framer_core.sv */
// top level of the modbus rtu request framer: sequencer, crc register and output register
//
//  channel  dir  handshake            beat
//  req      in   req_valid/req_stall  one request (req_t)
//  frm      out  frm_valid/frm_stall  one frame byte (frm_t)
//  cfg      in   cfg_valid/cfg_ready  slave address, 8 bit
//
//  a frame is 8, 11 or 15 bytes long for a read, write or read/write request
//  one byte a cycle through the single crc byte unit, with no stall on frm
//  a request with func 3 is taken and gives no bytes
//  req_stall is high from acceptance until the crc high byte is registered
//  a stall on frm holds the sequencer; reset gives slave address 1
module modbus_rtu_request_framer_core
	import mrf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  req_t       req,
	output logic       frm_valid,
	input  logic       frm_stall,
	output frm_t       frm,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);

	mrf_state_t      state_q;
	mrf_state_t      state_d;
	req_t            req_q;
	logic [IdxW-1:0] idx_q;
	logic [15:0]     crc_q;
	logic [7:0]      slave_q;
	logic            frm_valid_q;
	frm_t            frm_q;

	logic            take;
	logic            advance;
	logic            emit;
	frm_t            frm_d;
	logic [7:0]      body_byte;
	logic [15:0]     crc_next;
	logic            body_end;

	assign cfg_ready = 1'b1;
	assign req_stall = (state_q != ST_IDLE);
	assign take      = req_valid && !req_stall;
	assign advance   = !frm_valid_q || !frm_stall;
	assign body_byte = mrf_body_byte(slave_q, req_q, idx_q);
	assign body_end  = (idx_q == mrf_body_len(req_q.func) - IdxW'(1));

	mrf_crc_step u_crc (
		.crc      (crc_q),
		.data     (body_byte),
		.crc_next (crc_next)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (take && req.func != FUNC_NONE) begin
					state_d = ST_BODY;
				end
			end
			ST_BODY: begin
				if (advance && body_end) begin
					state_d = ST_CRC_LO;
				end
			end
			ST_CRC_LO: begin
				if (advance) begin
					state_d = ST_CRC_HI;
				end
			end
			ST_CRC_HI: begin
				if (advance) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		emit  = 1'b0;
		frm_d = '{frame_byte: body_byte, last_byte: 1'b0};
		unique case (state_q)
			ST_IDLE: emit = 1'b0;
			ST_BODY: emit = advance;
			ST_CRC_LO: begin
				emit  = advance;
				frm_d = '{frame_byte: crc_q[7:0], last_byte: 1'b0};
			end
			ST_CRC_HI: begin
				emit  = advance;
				frm_d = '{frame_byte: crc_q[15:8], last_byte: 1'b1};
			end
			default: emit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			slave_q     <= SLAVE_RESET;
			frm_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				slave_q <= cfg_data;
			end
			if (emit) begin
				frm_valid_q <= 1'b1;
			end else if (!frm_stall) begin
				frm_valid_q <= 1'b0;
			end
			if (take) begin
				idx_q <= '0;
			end else if (state_q == ST_BODY && advance) begin
				idx_q <= idx_q + IdxW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			req_q <= req;
			crc_q <= CRC_INIT;
		end else if (state_q == ST_BODY && advance) begin
			crc_q <= crc_next;
		end
		if (emit) begin
			frm_q <= frm_d;
		end
	end

	assign frm_valid = frm_valid_q;
	assign frm       = frm_q;

endmodule

/* rtl/mrf_checker.sv */
// port-level checks for the modbus rtu request framer, with bind
module mrf_checker
	import mrf_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input req_t req,
	input logic frm_valid,
	input logic frm_stall,
	input frm_t frm
);

	// stalled beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		frm_valid && frm_stall |=> frm_valid && $stable(frm))
		else $error("stalled frame beat changed");

	// a real request is followed by a frame beat, through the state and output registers
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req.func != FUNC_NONE |-> ##2 frm_valid)
		else $error("no frame beat after request");

	// a frame never ends straight after another ends
	assert property (@(posedge clk) disable iff (!arst_n)
		frm_valid && !frm_stall && frm.last_byte |=> !(frm_valid && frm.last_byte))
		else $error("last byte straight after last byte");

	// ready only with no partial frame pending
	assert property (@(posedge clk) disable iff (!arst_n)
		!req_stall |-> !frm_valid || frm.last_byte)
		else $error("request taken while frame incomplete");

endmodule

bind modbus_rtu_request_framer_core mrf_checker u_mrf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.frm_valid (frm_valid),
	.frm_stall (frm_stall),
	.frm       (frm)
);
